>>> hw/rtl/olir_pkg.sv
// Shared types, codes and constants for the ordered list block.
package olir_pkg;

    // Default number of entries held by the list
    localparam int CAPACITY_DEF = 64;

    // Width of position/count compares; covers the largest supported capacity (1024)
    localparam int CMP_W = 11;

    // Number of cells whose read outputs are merged in one registered group
    localparam int GROUP = 8;

    // Request action codes
    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_INSERT = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_READ   = 3'd3;
    localparam logic [2:0] ACT_WRITE  = 3'd4;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Update applied by every cell in the chain
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_WRITE
    } cell_op_t;

    // Command broadcast to the cells
    typedef struct packed {
        cell_op_t           op;
        logic [CMP_W-1:0]   pos;
        logic [CMP_W-1:0]   count;
        logic signed [31:0] value;
    } cell_cmd_t;

    // Request word
    typedef struct packed {
        logic [2:0]         action;
        logic [6:0]         position;
        logic signed [31:0] value;
    } req_t;

    // Result word
    typedef struct packed {
        logic signed [31:0] read_data;
        logic [6:0]         count;
        logic [1:0]         status;
    } rsp_t;

endpackage

>>> hw/rtl/olir_cell.sv
// One list entry: holds a word and takes its own, a neighbor's or a new value.
module olir_cell #(
    parameter int INDEX = 0
) (
    input  logic                    clk,
    input  olir_pkg::cell_cmd_t     cmd,
    input  logic signed [31:0]      left_data,
    input  logic signed [31:0]      right_data,
    output logic signed [31:0]      data,
    output logic signed [31:0]      read_data
);

    localparam logic [olir_pkg::CMP_W-1:0] IDX = olir_pkg::CMP_W'(INDEX);
    localparam logic [olir_pkg::CMP_W-1:0] ONE = olir_pkg::CMP_W'(1);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    // Pick the next entry value from the broadcast command
    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            olir_pkg::CELL_APPEND:
            begin
                if (IDX == cmd.count)
                    data_next = cmd.value;
            end
            olir_pkg::CELL_INSERT:
            begin
                if (IDX == cmd.pos)
                    data_next = cmd.value;
                else if (IDX > cmd.pos && IDX <= cmd.count)
                    data_next = left_data;
            end
            olir_pkg::CELL_REMOVE:
            begin
                if (IDX >= cmd.pos && IDX < cmd.count)
                begin
                    if (IDX + ONE == cmd.count)
                        data_next = '0;
                    else
                        data_next = right_data;
                end
            end
            olir_pkg::CELL_WRITE:
            begin
                if (IDX == cmd.pos)
                    data_next = cmd.value;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Hold the entry; no reset, entries are written before they are read
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    // Drive the entry onto the read merge only when addressed
    assign read_data = (IDX == cmd.pos) ? data_reg : '0;

endmodule

>>> hw/rtl/ordered_list_insert_remove.sv
// Top level of the ordered list: request control, cell chain and read merge.
//
// A fixed-capacity ordered list of signed 32-bit words, one word per cell in a
// chain of CAPACITY cells. Each request word (append, insert before position,
// remove at position, read, write) updates every cell at once, each cell taking
// its own, its left or right neighbor's, or the new value, so one request is
// accepted every cycle while the result stages do not stall. The result word passes
// through the first register stage, which holds status, count and per-group
// merges of the addressed cell (GROUP cells each), and then the output register,
// which finishes the read merge. A request is accepted while a result waits as
// long as the first stage can move on. After reset the list is empty and usable
// at once; entries carry no reset and only written entries are ever returned.
module ordered_list_insert_remove #(
    parameter int CAPACITY = olir_pkg::CAPACITY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  olir_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output olir_pkg::rsp_t rsp
);

    localparam int CW      = olir_pkg::CMP_W;
    localparam int NGROUPS = (CAPACITY + olir_pkg::GROUP - 1) / olir_pkg::GROUP;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                accept;
    logic [CW-1:0]       pos;
    olir_pkg::status_t   status;
    logic                read_hit;
    olir_pkg::cell_cmd_t cmd;

    logic signed [31:0] cell_data [CAPACITY];
    logic signed [31:0] cell_rd   [CAPACITY];
    logic signed [31:0] group_next [NGROUPS];
    logic signed [31:0] group_reg  [NGROUPS];

    logic               pend_valid_reg;
    logic [6:0]         pend_count_reg;
    olir_pkg::status_t  pend_status_reg;
    logic               pend_hit_reg;
    logic               pend_move;
    logic signed [31:0] merged;

    logic               out_valid_reg;
    olir_pkg::rsp_t     out_reg;

    assign pend_move = pend_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !pend_valid_reg || pend_move;
    assign accept    = req_valid && req_ready;
    assign pos       = CW'(req.position);

    // Check the request and build the command for the cells
    always_comb
    begin
        status     = olir_pkg::ST_OK;
        read_hit   = 1'b0;
        count_next = count_reg;
        cmd.op     = olir_pkg::CELL_HOLD;
        cmd.pos    = pos;
        cmd.count  = count_reg;
        cmd.value  = req.value;
        case (req.action)
            olir_pkg::ACT_APPEND:
            begin
                if (count_reg >= CAP)
                    status = olir_pkg::ST_FULL;
                else
                begin
                    cmd.op     = olir_pkg::CELL_APPEND;
                    count_next = count_reg + ONE;
                end
            end
            olir_pkg::ACT_INSERT:
            begin
                if (pos > count_reg)
                    status = olir_pkg::ST_RANGE;
                else if (count_reg >= CAP)
                    status = olir_pkg::ST_FULL;
                else
                begin
                    cmd.op     = olir_pkg::CELL_INSERT;
                    count_next = count_reg + ONE;
                end
            end
            olir_pkg::ACT_REMOVE:
            begin
                if (pos >= count_reg)
                    status = olir_pkg::ST_RANGE;
                else
                begin
                    cmd.op     = olir_pkg::CELL_REMOVE;
                    count_next = count_reg - ONE;
                end
            end
            olir_pkg::ACT_READ:
            begin
                if (pos >= count_reg)
                    status = olir_pkg::ST_RANGE;
                else
                    read_hit = 1'b1;
            end
            olir_pkg::ACT_WRITE:
            begin
                if (pos >= count_reg)
                    status = olir_pkg::ST_RANGE;
                else
                    cmd.op = olir_pkg::CELL_WRITE;
            end
            default:
            begin
                status = olir_pkg::ST_OK;
            end
        endcase
        // Drop the update unless the word is actually taken
        if (!accept)
        begin
            cmd.op     = olir_pkg::CELL_HOLD;
            count_next = count_reg;
        end
    end

    // Chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] left_data;
        logic signed [31:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        olir_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .read_data  (cell_rd[i])
        );
    end

    // Merge the addressed cell within each group
    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            group_next[g] = '0;
            for (int j = 0; j < olir_pkg::GROUP; j++)
            begin
                if (g * olir_pkg::GROUP + j < CAPACITY)
                    group_next[g] = group_next[g] | cell_rd[g * olir_pkg::GROUP + j];
            end
        end
    end

    // Finish the read merge across groups
    always_comb
    begin
        merged = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            merged = merged | group_reg[g];
        end
    end

    // Hold the list length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Advance the first result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (accept)
            pend_valid_reg <= 1'b1;
        else if (pend_move)
            pend_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_count_reg  <= count_next[6:0];
            pend_status_reg <= status;
            pend_hit_reg    <= read_hit;
            for (int g = 0; g < NGROUPS; g++)
            begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    // Advance the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pend_move)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pend_move)
        begin
            out_reg.read_data <= pend_hit_reg ? merged : '0;
            out_reg.count     <= pend_count_reg;
            out_reg.status    <= pend_status_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
